[rtl/core/efws_pkg.sv]
// Shared types and constants for the earliest-free-worker scheduler.
package efws_pkg;

    // Built worker count and derived widths
    localparam int WORKERS = 16;
    localparam int IDX_W   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int CNT_W   = $clog2(WORKERS + 1);
    localparam int LEVELS  = $clog2(WORKERS);
    localparam int LEAVES  = 1 << LEVELS;

    // Field widths
    localparam int ID_W    = 16;
    localparam int DUR_W   = 16;
    localparam int DAY_W   = 32;
    localparam int WRK_W   = 4;
    localparam int CFG_W   = 5;

    // Reset value of the worker count register
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    // Input beat
    typedef struct packed {
        logic [ID_W-1:0]  job_id;
        logic [DUR_W-1:0] duration;
        logic             last_job;
    } t_in;

    // Result beat
    typedef struct packed {
        logic [WRK_W-1:0] assigned_worker;
        logic [DAY_W-1:0] start_day;
        logic             batch_done;
        logic [DAY_W-1:0] total_days;
    } t_out;

    // Selection key: compared as one unsigned word, smallest wins
    typedef struct packed {
        logic [DAY_W-1:0] finish;
        logic             had;
        logic [ID_W-1:0]  id;
    } t_key;

endpackage

[rtl/core/efws_select.sv]
// Parallel minimum tree that picks the worker with the smallest selection key.
module efws_select (
    input  efws_pkg::t_key                     i_key [efws_pkg::WORKERS],
    input  logic [efws_pkg::WORKERS-1:0]       i_vld,
    output logic [efws_pkg::IDX_W-1:0]         o_best
);

    localparam int NODES = 2 * efws_pkg::LEAVES - 1;

    efws_pkg::t_key             node_key [NODES];
    logic                       node_vld [NODES];
    logic [efws_pkg::IDX_W-1:0] node_idx [NODES];

    // Place workers at the leaves, pad unused leaves as invalid
    for (genvar l = 0; l < efws_pkg::LEAVES; l++) begin : g_leaf
        if (l < efws_pkg::WORKERS) begin : g_used
            assign node_key[efws_pkg::LEAVES-1+l] = i_key[l];
            assign node_vld[efws_pkg::LEAVES-1+l] = i_vld[l];
        end else begin : g_pad
            assign node_key[efws_pkg::LEAVES-1+l] = '0;
            assign node_vld[efws_pkg::LEAVES-1+l] = 1'b0;
        end
        assign node_idx[efws_pkg::LEAVES-1+l] = efws_pkg::IDX_W'(l);
    end

    // Reduce pairwise; the left (lower index) child wins on equal keys
    for (genvar n = 0; n < efws_pkg::LEAVES - 1; n++) begin : g_node
        logic take_b;
        assign take_b = node_vld[2*n+2] &&
                        (!node_vld[2*n+1] || (node_key[2*n+2] < node_key[2*n+1]));
        assign node_key[n] = take_b ? node_key[2*n+2] : node_key[2*n+1];
        assign node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
        assign node_idx[n] = take_b ? node_idx[2*n+2] : node_idx[2*n+1];
    end

    assign o_best = node_idx[0];

endmodule

[rtl/core/earliest_free_worker_scheduler_top.sv]
// Top level of the earliest-free-worker scheduler.
// Datapath: an accepted input beat waits in the input register, and its result beat
// is written to the output register when the worker table takes the job.
// Throughput: one job per cycle unless the output stalls; the worker table is updated
// in the same cycle that the minimum tree picks a worker, so the next job sees the new state.
// Reset: synchronous, active low; clears worker finish days, job flags, the
// running batch maximum and both valid flags, and sets the worker count to 16.
module earliest_free_worker_scheduler_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  efws_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output efws_pkg::t_out                o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [efws_pkg::CFG_W-1:0]    i_cfg_data
);

    logic                          r_in_vld;
    efws_pkg::t_in                 r_in;
    logic                          r_out_vld;
    efws_pkg::t_out                r_out;
    logic [efws_pkg::CFG_W-1:0]    r_cfg;
    logic [efws_pkg::DAY_W-1:0]    r_finish [efws_pkg::WORKERS];
    logic [efws_pkg::WORKERS-1:0]  r_had;
    logic [efws_pkg::ID_W-1:0]     r_held   [efws_pkg::WORKERS];
    logic [efws_pkg::DAY_W-1:0]    r_max;

    logic                          advance;
    logic [efws_pkg::CNT_W-1:0]    count_eff;
    logic [efws_pkg::WORKERS-1:0]  in_use;
    efws_pkg::t_key                key [efws_pkg::WORKERS];
    logic [efws_pkg::IDX_W-1:0]    best;
    logic [efws_pkg::DAY_W-1:0]    start;
    logic [efws_pkg::DAY_W:0]      sum;
    logic [efws_pkg::DAY_W-1:0]    fin;
    logic [efws_pkg::DAY_W-1:0]    n_max;
    logic [efws_pkg::IDX_W+efws_pkg::WRK_W-1:0] best_wide;
    efws_pkg::t_out                n_out;

    // Stage handshake
    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // Clamp the worker count to 1..WORKERS
    always_comb begin
        if (r_cfg == '0) begin
            count_eff = efws_pkg::CNT_W'(1);
        end else if (32'(r_cfg) > efws_pkg::WORKERS) begin
            count_eff = efws_pkg::CNT_W'(efws_pkg::WORKERS);
        end else begin
            count_eff = efws_pkg::CNT_W'(r_cfg);
        end
    end

    // Build selection keys; held id counts only once a worker has had a job
    for (genvar w = 0; w < efws_pkg::WORKERS; w++) begin : g_key
        assign in_use[w]     = 32'(count_eff) > w;
        assign key[w].finish = r_finish[w];
        assign key[w].had    = r_had[w];
        assign key[w].id     = r_had[w] ? r_held[w] : '0;
    end

    efws_select u_select (
        .i_key  (key),
        .i_vld  (in_use),
        .o_best (best)
    );

    // Start day, saturating finish day and running batch maximum
    always_comb begin
        start = r_finish[best];
        sum   = {1'b0, start} + (efws_pkg::DAY_W + 1)'(r_in.duration);
        fin   = sum[efws_pkg::DAY_W] ? '1 : sum[efws_pkg::DAY_W-1:0];
        n_max = (fin > r_max) ? fin : r_max;
    end

    // Assemble the result beat
    always_comb begin
        best_wide             = {{efws_pkg::WRK_W{1'b0}}, best};
        n_out.assigned_worker = best_wide[efws_pkg::WRK_W-1:0];
        n_out.start_day       = start;
        n_out.batch_done      = r_in.last_job;
        n_out.total_days      = r_in.last_job ? n_max : '0;
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= efws_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Input stage: hold the beat until the worker table takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // Worker table: update the chosen worker, clear all at the end of a batch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < efws_pkg::WORKERS; w++) begin
                r_finish[w] <= '0;
            end
            r_had <= '0;
            r_max <= '0;
        end else if (advance) begin
            if (r_in.last_job) begin
                for (int w = 0; w < efws_pkg::WORKERS; w++) begin
                    r_finish[w] <= '0;
                end
                r_had <= '0;
                r_max <= '0;
            end else begin
                r_finish[best] <= fin;
                r_had[best]    <= 1'b1;
                r_max          <= n_max;
            end
        end
    end

    // Held job ids need no reset: read only behind the job flag
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_held[best] <= r_in.job_id;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/core/efws_checker.sv]
// Port-level checker for the earliest-free-worker scheduler, bound to the top level.
module efws_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input efws_pkg::t_out o_out_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // Drop output valid after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Report a total only at the end of a batch
    a_total_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.batch_done |-> o_out_data.total_days == '0)
        else $error("total days outside a batch end");

    // The batch total covers this job's start
    a_total_ge_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.batch_done |->
            o_out_data.total_days >= o_out_data.start_day)
        else $error("batch total below the last start day");

    // Assigned worker is a built worker
    a_worker_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out_data.assigned_worker) < efws_pkg::WORKERS)
        else $error("assigned worker out of range");

endmodule

bind earliest_free_worker_scheduler_top efws_checker u_efws_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
